/* src/prefix_code_encoder_defines.svh */
// Assertion macros for the prefix code encoder checker.
// No dependencies; included by the checker file only.
`ifndef PREFIX_CODE_ENCODER_DEFINES_SVH
`define PREFIX_CODE_ENCODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PCE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/pce_pkg.sv */
// Shared types, codes and helpers of the prefix code encoder.
// No dependencies; used by every module of the block but the checker.
package pce_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int CODE_CAP     = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
   localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Request modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

   // Operation kinds passed from front to back
   localparam logic [1:0] OP_ENCODE = 2'd0;
   localparam logic [1:0] OP_ERROR  = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code;
      logic [4:0]  len;
   } op_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   // Mask of the n low bits, n up to 16.
   function automatic logic [15:0] low_mask(logic [4:0] n);
      logic [16:0] w;
      w = (17'd1 << n) - 17'd1;
      return w[15:0];
   endfunction

endpackage

/* src/pce_front.sv */
// Front end: accepts requests, owns the code table and valid bits, classifies.
// Depends on pce_pkg.
module pce_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_symbol,
   input  logic [15:0]         req_code_value,
   input  logic [4:0]          req_code_length,
   input  pce_pkg::q_stat_type q_stat,
   output logic                op_push,
   output pce_pkg::op_type     op_data
);

   logic [15:0] code_mem [pce_pkg::SYMBOL_COUNT];
   logic [4:0]  len_mem  [pce_pkg::SYMBOL_COUNT];

   logic [pce_pkg::SYMBOL_COUNT-1:0] valid_ff, valid_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic [1:0]                       s1_kind_ff, s1_kind_in;
   logic [15:0]                      rd_code_ff;
   logic [4:0]                       rd_len_ff;

   logic                          accept, in_range, is_load, is_encode, is_flush;
   logic [pce_pkg::SYM_IDX_W-1:0] idx;
   logic [4:0]                    clen_sat;

   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_symbol} < 9'(pce_pkg::SYMBOL_COUNT);
   assign idx       = req_symbol[pce_pkg::SYM_IDX_W-1:0];
   assign is_load   = req_mode == pce_pkg::MODE_LOAD;
   assign is_encode = req_mode == pce_pkg::MODE_ENCODE;
   assign is_flush  = req_mode == pce_pkg::MODE_FLUSH;
   assign clen_sat  = (req_code_length > 5'(pce_pkg::CODE_CAP)) ?
                      5'(pce_pkg::CODE_CAP) : req_code_length;

   assign op_push   = s1_valid_ff && !q_stat.full;
   assign req_ready = !s1_valid_ff || !q_stat.full;
   assign op_data   = '{kind: s1_kind_ff, code: rd_code_ff, len: rd_len_ff};

   always_comb begin
      valid_in = valid_ff;
      if (accept && is_load && in_range) begin
         valid_in[idx] = clen_sat != 5'd0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !op_push;
      if (accept && (is_encode || is_flush)) begin
         s1_valid_in = 1'b1;
      end
      if (is_flush) begin
         s1_kind_in = pce_pkg::OP_FLUSH;
      end else if (in_range && valid_ff[idx]) begin
         s1_kind_in = pce_pkg::OP_ENCODE;
      end else begin
         s1_kind_in = pce_pkg::OP_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         code_mem[idx] <= req_code_value;
         len_mem[idx]  <= clen_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= s1_kind_in;
      end
      if (accept && is_encode) begin
         rd_code_ff <= code_mem[idx];
         rd_len_ff  <= len_mem[idx];
      end
   end

endmodule

/* src/pce_queue.sv */
// Short operation queue between front and back.
// Depends on pce_pkg.
module pce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pce_pkg::op_type     push_data,
   input  logic                pop,
   output pce_pkg::op_type     head,
   output pce_pkg::q_stat_type stat
);

   pce_pkg::op_type            entry_ff [pce_pkg::QUEUE_DEPTH];
   logic [pce_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [pce_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [pce_pkg::QPTR_W-1:0] next_ptr(logic [pce_pkg::QPTR_W-1:0] p);
      return (p == pce_pkg::QPTR_W'(pce_pkg::QUEUE_DEPTH - 1)) ?
             '0 : p + pce_pkg::QPTR_W'(1);
   endfunction

   assign stat.full      = cnt_ff == pce_pkg::QCNT_W'(pce_pkg::QUEUE_DEPTH);
   assign stat.not_empty = cnt_ff != '0;
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + pce_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - pce_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/pce_back.sv */
// Back end: bit packer, byte buffer and result output register.
// Depends on pce_pkg.
module pce_back (
   input  logic                clock,
   input  logic                reset,
   input  pce_pkg::op_type     head,
   input  pce_pkg::q_stat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_is_error,
   output logic                rsp_last
);

   logic [7:0]  pend_ff, pend_in;
   logic [2:0]  fill_ff, fill_in;
   logic [1:0]  bb_cnt_ff, bb_cnt_in;
   logic [15:0] bb_data_ff, bb_data_in;
   logic        bb_err_ff, bb_err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        is_error_ff, last_ff;

   logic        move, bb_next_empty;
   logic [23:0] acc;
   logic [15:0] sh;
   logic [4:0]  total;
   logic [7:0]  new_pend, flush_byte;

   assign move          = (bb_cnt_ff != 2'd0) && (!rsp_valid_ff || rsp_ready);
   assign bb_next_empty = (bb_cnt_ff == 2'd0) || ((bb_cnt_ff == 2'd1) && move);
   assign pop           = q_stat.not_empty && bb_next_empty;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_error = is_error_ff;
   assign rsp_last     = last_ff;

   // Append the code below the pending bits and split off whole bytes.
   always_comb begin
      acc        = ({16'h0000, pend_ff} << head.len) |
                   {8'h00, head.code & pce_pkg::low_mask(head.len)};
      total      = 5'({2'b00, fill_ff}) + head.len;
      sh         = 16'(acc >> total[2:0]);
      new_pend   = acc[7:0] & (8'hFF >> (4'd8 - {1'b0, total[2:0]}));
      flush_byte = pend_ff << (4'd8 - {1'b0, fill_ff});
   end

   always_comb begin
      pend_in    = pend_ff;
      fill_in    = fill_ff;
      bb_cnt_in  = bb_cnt_ff;
      bb_data_in = bb_data_ff;
      bb_err_in  = bb_err_ff;
      if (move) begin
         bb_cnt_in  = bb_cnt_ff - 2'd1;
         bb_data_in = {bb_data_ff[7:0], 8'h00};
      end
      if (pop) begin
         case (head.kind)
            pce_pkg::OP_ENCODE: begin
               pend_in    = new_pend;
               fill_in    = total[2:0];
               bb_cnt_in  = total[4:3];
               bb_data_in = (total[4:3] == 2'd2) ? sh[15:0] : {sh[7:0], 8'h00};
               bb_err_in  = 1'b0;
            end
            pce_pkg::OP_ERROR: begin
               bb_cnt_in  = 2'd1;
               bb_data_in = 16'h0000;
               bb_err_in  = 1'b1;
            end
            pce_pkg::OP_FLUSH: begin
               pend_in    = 8'h00;
               fill_in    = 3'd0;
               bb_cnt_in  = 2'd1;
               bb_data_in = {flush_byte, 8'h00};
               bb_err_in  = 1'b0;
            end
            default: begin
               bb_cnt_in = 2'd0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 8'h00;
         fill_ff      <= 3'd0;
         bb_cnt_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         bb_cnt_ff    <= bb_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bb_data_ff <= bb_data_in;
      bb_err_ff  <= bb_err_in;
      if (move) begin
         out_byte_ff <= bb_data_ff[15:8];
         is_error_ff <= bb_err_ff;
         last_ff     <= bb_cnt_ff == 2'd1;
      end
   end

endmodule

/* src/prefix_code_encoder.sv */
// Prefix code encoder: requests pass the front stage, queue, byte buffer and result
// register. One request per cycle while the queue has room; a request that completes
// two bytes holds the back end while the single result register drains one byte a
// cycle, as rsp_ready allows. Reset (synchronous, active high) clears all table valid
// bits, the packer and the queue at once; table contents stay undefined until loaded.
module prefix_code_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_code_value,
   input  logic [4:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_error,
   output logic        rsp_last
);

   // Front to queue: one operation per push, stall on a full queue.
   pce_pkg::op_type     op_data;
   pce_pkg::op_type     q_head;
   pce_pkg::q_stat_type q_stat;
   logic                op_push;
   logic                op_pop;

   // Accept requests, write the code table on loads, look up codes on encodes.
   pce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .q_stat          (q_stat),
      .op_push         (op_push),
      .op_data         (op_data)
   );

   // Hold classified operations so front and back stall independently.
   pce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_data),
      .pop       (op_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Pack code bits into bytes and drain them through the result register.
   pce_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_stat       (q_stat),
      .pop          (op_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_error (rsp_is_error),
      .rsp_last     (rsp_last)
   );

endmodule

/* src/pce_checker.sv */
// Port-level checker for the prefix code encoder, bound to the top level.
// Depends on prefix_code_encoder_defines.svh.
`include "prefix_code_encoder_defines.svh"

module pce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_is_error,
   input logic        rsp_last
);

   `PCE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_is_error), "result changed while stalled")
   `PCE_ASSERT(a_err_form, rsp_valid && rsp_is_error |-> rsp_last && rsp_out_byte == 8'h00, "error result malformed")
   `PCE_ASSERT_ALWAYS(a_reset_clean, $past(reset) && !reset |-> !rsp_valid && req_ready, "not clean after reset")
   `PCE_ASSERT(a_err_after_last, rsp_valid && rsp_ready && !rsp_last |=> !(rsp_valid && rsp_is_error), "error inside a multi-byte request")

endmodule

bind prefix_code_encoder pce_checker u_pce_checker (.*);
